// ===== rtl/ftage_pkg.sv =====
// shared types and constants of the flow table with aging
`timescale 1ns / 1ps
`default_nettype none
package ftage_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int KEY_W       = 104;
    localparam int THR_W       = 26;

    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_SWEEP  = 2'd2;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_MAXFLOW = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [3:0]        cls;
        logic [47:0]       first_ms;
        logic [47:0]       last_ms;
        logic [31:0]       packets;
        logic [47:0]       bytes;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic cmp;
        logic step;
        logic wr_clear;
        logic wr_hit;
        logic miss;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       hit;
        logic       expire;
        logic       at_end;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/flow_table_with_aging_core.sv =====
// top level of the five-tuple flow table with idle aging
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; its single result word
// appears for one cycle with done high and cannot be held off. A packet,
// lookup or sweep request scans the entry memory one entry at a time (read, then
// compare), since the single-port entry memory is the only store of keys. A hit
// on an entry ends the scan (a packet then writes the entry back), a miss or a
// sweep walks all 1024 entries, and a packet that misses then creates the entry
// or drops it. An unused request code skips the scan. After reset a clearing
// pass over all 1024 entries empties the table with busy high; configuration
// writes are taken at any time (cfg_ready is always high).
module flow_table_with_aging_core
    import ftage_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic [1:0]        req_type,
    input  wire logic [31:0]       src_ip,
    input  wire logic [31:0]       dst_ip,
    input  wire logic [15:0]       src_port,
    input  wire logic [15:0]       dst_port,
    input  wire logic [7:0]        ip_proto,
    input  wire logic [3:0]        protocol_hint,
    input  wire logic [47:0]       time_ms,
    input  wire logic [15:0]       pkt_len,
    output logic                   found,
    output logic                   created,
    output logic                   table_full,
    output logic [3:0]             flow_protocol,
    output logic [47:0]            first_seen_ms,
    output logic [47:0]            last_seen_ms,
    output logic [31:0]            pkt_total,
    output logic [47:0]            octet_total,
    output logic [CNT_W-1:0]       expired_count
);
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    ftage_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ftage_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .src_ip        (src_ip),
        .dst_ip        (dst_ip),
        .src_port      (src_port),
        .dst_port      (dst_port),
        .ip_proto      (ip_proto),
        .protocol_hint (protocol_hint),
        .time_ms       (time_ms),
        .pkt_len       (pkt_len),
        .found         (found),
        .created       (created),
        .table_full    (table_full),
        .flow_protocol (flow_protocol),
        .first_seen_ms (first_seen_ms),
        .last_seen_ms  (last_seen_ms),
        .pkt_total     (pkt_total),
        .octet_total   (octet_total),
        .expired_count (expired_count)
    );

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result word while idle");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result word held more than one cycle");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({found, created, table_full}))
        else $error("conflicting result flags");
    a_sweep_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && expired_count != '0) |-> !found && !created && !table_full)
        else $error("sweep word carries entry flags");
`endif
endmodule
`default_nettype wire

// ===== rtl/ftage_ctrl.sv =====
// controller state machine of the flow table
`timescale 1ns / 1ps
`default_nettype none
module ftage_ctrl
    import ftage_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output cmd_t       cmd,
    output logic       busy,
    output logic       done
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_MISS  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_clear = 1'b1;
                cmd.step     = 1'b1;
                if (stat.at_end)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (stat.req == REQ_PACKET || stat.req == REQ_LOOKUP
                    || stat.req == REQ_SWEEP)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CMP;
                end
                else
                    state_next = ST_OUT;
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (stat.req == REQ_SWEEP)
                begin
                    cmd.wr_clear = stat.expire;
                    if (stat.at_end)
                        state_next = ST_OUT;
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_RD;
                    end
                end
                else if (stat.hit)
                    state_next = (stat.req == REQ_PACKET) ? ST_WR : ST_OUT;
                else if (stat.at_end)
                    state_next = (stat.req == REQ_PACKET) ? ST_MISS : ST_OUT;
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_WR:
            begin
                cmd.wr_hit = 1'b1;
                state_next = ST_OUT;
            end
            ST_MISS:
            begin
                cmd.miss   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_OUT);
endmodule
`default_nettype wire

// ===== rtl/ftage_dp.sv =====
// datapath of the flow table: entry memory, scan registers, result registers
`timescale 1ns / 1ps
`default_nettype none
module ftage_dp
    import ftage_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cmd_t         cmd,
    output stat_t             stat,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic [1:0]   req_type,
    input  wire logic [31:0]  src_ip,
    input  wire logic [31:0]  dst_ip,
    input  wire logic [15:0]  src_port,
    input  wire logic [15:0]  dst_port,
    input  wire logic [7:0]   ip_proto,
    input  wire logic [3:0]   protocol_hint,
    input  wire logic [47:0]  time_ms,
    input  wire logic [15:0]  pkt_len,
    output logic              found,
    output logic              created,
    output logic              table_full,
    output logic [3:0]        flow_protocol,
    output logic [47:0]       first_seen_ms,
    output logic [47:0]       last_seen_ms,
    output logic [31:0]       pkt_total,
    output logic [47:0]       octet_total,
    output logic [CNT_W-1:0]  expired_count
);
    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg, upd_reg, upd_next, wr_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [15:0]       timeout_reg;
    logic [CNT_W-1:0]  maxf_reg, live_reg, removed_reg;
    logic [1:0]        req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [3:0]        hint_reg;
    logic [47:0]       t_reg;
    logic [15:0]       len_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [ADDR_W-1:0] addr_reg, free_reg;
    logic              free_vld_reg;
    logic              new_ok;
    logic [47:0]       age;
    logic [48:0]       bsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd300;
            maxf_reg    <= CNT_W'(TABLE_DEPTH);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TIMEOUT)
                timeout_reg <= cfg_data;
            else
                maxf_reg <= cfg_data[CNT_W-1:0];
        end
    end

    // hit update with saturating counters
    always_comb
    begin
        upd_next         = rd_reg;
        upd_next.last_ms = t_reg;
        if (rd_reg.packets != 32'hFFFF_FFFF)
            upd_next.packets = rd_reg.packets + 32'd1;
        bsum = {1'b0, rd_reg.bytes} + {33'd0, len_reg};
        upd_next.bytes = bsum[48] ? 48'hFFFF_FFFF_FFFF : bsum[47:0];
        if (hint_reg != 4'd0 && rd_reg.cls == 4'd0)
            upd_next.cls = hint_reg;
    end

    assign age         = t_reg - rd_reg.last_ms;
    assign stat.req    = req_reg;
    assign stat.hit    = rd_reg.valid && (rd_reg.key == key_reg);
    assign stat.expire = rd_reg.valid && (t_reg >= rd_reg.last_ms)
                         && (age > {{(48-THR_W){1'b0}}, thr_reg});
    assign stat.at_end = (addr_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign new_ok      = free_vld_reg && (live_reg < maxf_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        priority if (cmd.wr_clear)
            wr_en = 1'b1;
        else if (cmd.wr_hit)
        begin
            wr_en   = 1'b1;
            wr_data = upd_reg;
        end
        else if (cmd.miss && new_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = free_reg;
            wr_data = '{valid: 1'b1, key: key_reg, cls: hint_reg, first_ms: t_reg,
                        last_ms: t_reg, packets: 32'd1, bytes: {32'd0, len_reg}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd)
            rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            live_reg     <= '0;
            free_vld_reg <= 1'b0;
            free_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                addr_reg     <= '0;
                free_vld_reg <= 1'b0;
            end
            else if (cmd.step)
                addr_reg <= addr_reg + ADDR_W'(1);
            if (cmd.cmp && !rd_reg.valid && !free_vld_reg)
            begin
                free_vld_reg <= 1'b1;
                free_reg     <= addr_reg;
            end
            if (cmd.cmp && req_reg == REQ_SWEEP && stat.expire && live_reg != '0)
                live_reg <= live_reg - CNT_W'(1);
            else if (cmd.miss && new_ok)
                live_reg <= live_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= req_type;
            key_reg       <= {src_ip, dst_ip, src_port, dst_port, ip_proto};
            hint_reg      <= protocol_hint;
            t_reg         <= time_ms;
            len_reg       <= pkt_len;
            thr_reg       <= THR_W'({10'd0, timeout_reg} * 26'd1000 + 26'd999);
            removed_reg   <= '0;
            found         <= 1'b0;
            created       <= 1'b0;
            table_full    <= 1'b0;
            flow_protocol <= '0;
            first_seen_ms <= '0;
            last_seen_ms  <= '0;
            pkt_total     <= '0;
            octet_total   <= '0;
            expired_count <= '0;
        end
        if (cmd.cmp && req_reg == REQ_SWEEP)
        begin
            if (stat.expire)
            begin
                removed_reg   <= removed_reg + CNT_W'(1);
                expired_count <= removed_reg + CNT_W'(1);
            end
        end
        else if (cmd.cmp && stat.hit)
        begin
            upd_reg <= upd_next;
            found   <= 1'b1;
            if (req_reg == REQ_PACKET)
            begin
                flow_protocol <= upd_next.cls;
                first_seen_ms <= upd_next.first_ms;
                last_seen_ms  <= upd_next.last_ms;
                pkt_total     <= upd_next.packets;
                octet_total   <= upd_next.bytes;
            end
            else
            begin
                flow_protocol <= rd_reg.cls;
                first_seen_ms <= rd_reg.first_ms;
                last_seen_ms  <= rd_reg.last_ms;
                pkt_total     <= rd_reg.packets;
                octet_total   <= rd_reg.bytes;
            end
        end
        if (cmd.miss)
        begin
            if (new_ok)
            begin
                created       <= 1'b1;
                flow_protocol <= hint_reg;
                first_seen_ms <= t_reg;
                last_seen_ms  <= t_reg;
                pkt_total     <= 32'd1;
                octet_total   <= {32'd0, len_reg};
            end
            else
                table_full <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench of the five-tuple flow table with idle aging
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import ftage_pkg::*;

    localparam int  POOL_SIZE   = 32;
    localparam int  CYCLE_LIMIT = 6000000;
    localparam int  DRAIN_WAIT  = 2200;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  ip_proto;
    } flow_key_t;

    typedef struct packed {
        logic [1:0]  req;
        flow_key_t   key;
        logic [3:0]  hint;
        logic [47:0] t_ms;
        logic [15:0] len;
    } flow_req_t;

    typedef struct packed {
        logic        found;
        logic        created;
        logic        table_full;
        logic [3:0]  proto;
        logic [47:0] first_ms;
        logic [47:0] last_ms;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [10:0] expired;
    } flow_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic start = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic [1:0] req_type = '0;
    logic [31:0] src_ip = '0;
    logic [31:0] dst_ip = '0;
    logic [15:0] src_port = '0;
    logic [15:0] dst_port = '0;
    logic [7:0] ip_proto = '0;
    logic [3:0] protocol_hint = '0;
    logic [47:0] time_ms = '0;
    logic [15:0] pkt_len = '0;
    logic busy, done, cfg_ready, found, created, table_full;
    logic [3:0] flow_protocol;
    logic [47:0] first_seen_ms, last_seen_ms, octet_total;
    logic [31:0] pkt_total;
    logic [CNT_W-1:0] expired_count;

    flow_table_with_aging_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted table contents
    logic        tbl_valid [TABLE_DEPTH];
    flow_key_t   tbl_key [TABLE_DEPTH];
    logic [3:0]  tbl_cls [TABLE_DEPTH];
    logic [47:0] tbl_first [TABLE_DEPTH];
    logic [47:0] tbl_last [TABLE_DEPTH];
    logic [31:0] tbl_pkts [TABLE_DEPTH];
    logic [47:0] tbl_bytes [TABLE_DEPTH];
    int unsigned live_flows;
    logic [15:0] timeout_sec;
    logic [10:0] flow_limit;

    flow_req_t  pending_reqs [$];
    flow_resp_t expected_resps [$];
    flow_key_t  key_pool [POOL_SIZE];
    int         mismatches = 0;
    int         gap_left = 0;
    bit         quiet_tail = 1'b0;
    logic [47:0] now_ms = '0;

    function automatic int find_flow(flow_key_t k);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic flow_resp_t entry_fields(int i, flow_resp_t r);
        r.proto = tbl_cls[i];
        r.first_ms = tbl_first[i];
        r.last_ms = tbl_last[i];
        r.packets = tbl_pkts[i];
        r.bytes = tbl_bytes[i];
        return r;
    endfunction

    task automatic update_flow_table(input flow_req_t q, output flow_resp_t r);
        int i;
        int f;
        logic [48:0] sum;
        logic [47:0] age;
        int unsigned removed;
        r = '0;
        removed = 0;
        f = -1;
        if (q.req == REQ_PACKET)
        begin
            i = find_flow(q.key);
            if (i >= 0)
            begin
                r.found = 1'b1;
                tbl_last[i] = q.t_ms;
                if (tbl_pkts[i] != 32'hFFFF_FFFF)
                    tbl_pkts[i] = tbl_pkts[i] + 32'd1;
                sum = {1'b0, tbl_bytes[i]} + {33'd0, q.len};
                tbl_bytes[i] = sum[48] ? MAX48 : sum[47:0];
                if (q.hint != 0 && tbl_cls[i] == 0)
                    tbl_cls[i] = q.hint;
                r = entry_fields(i, r);
            end
            else
            begin
                if (live_flows < flow_limit)
                    for (int j = 0; j < TABLE_DEPTH && f < 0; j++)
                        if (!tbl_valid[j])
                            f = j;
                if (f < 0)
                    r.table_full = 1'b1;
                else
                begin
                    tbl_valid[f] = 1'b1;
                    tbl_key[f] = q.key;
                    tbl_cls[f] = q.hint;
                    tbl_first[f] = q.t_ms;
                    tbl_last[f] = q.t_ms;
                    tbl_pkts[f] = 32'd1;
                    tbl_bytes[f] = {32'd0, q.len};
                    live_flows++;
                    r.created = 1'b1;
                    r = entry_fields(f, r);
                end
            end
        end
        else if (q.req == REQ_LOOKUP)
        begin
            i = find_flow(q.key);
            if (i >= 0)
            begin
                r.found = 1'b1;
                r = entry_fields(i, r);
            end
        end
        else if (q.req == REQ_SWEEP)
        begin
            for (int j = 0; j < TABLE_DEPTH; j++)
            begin
                if (!tbl_valid[j])
                    continue;
                // a sweep time behind the last packet counts as age zero
                age = (q.t_ms >= tbl_last[j]) ? (q.t_ms - tbl_last[j]) / 1000 : '0;
                if (age > timeout_sec)
                begin
                    tbl_valid[j] = 1'b0;
                    removed++;
                    if (live_flows > 0)
                        live_flows--;
                end
            end
            r.expired = removed[10:0];
        end
    endtask

    // driver: one start word at a time, with random idle bursts
    always @(posedge clk)
    begin
        flow_resp_t r;
        flow_req_t nx;
        logic want;
        want = start;
        if (start && !busy)
        begin
            update_flow_table(pending_reqs.pop_front(), r);
            expected_resps.insert(expected_resps.size(), r);
            want = 1'b0;
        end
        if (!want)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_reqs.size() > 0)
            begin
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 11);
                else
                begin
                    nx = pending_reqs[0];
                    want = 1'b1;
                    req_type <= nx.req;
                    src_ip <= nx.key.src_ip;
                    dst_ip <= nx.key.dst_ip;
                    src_port <= nx.key.src_port;
                    dst_port <= nx.key.dst_port;
                    ip_proto <= nx.key.ip_proto;
                    protocol_hint <= nx.hint;
                    time_ms <= nx.t_ms;
                    pkt_len <= nx.len;
                end
            end
        end
        start <= want;
    end

    // monitor: result words and register writes
    always @(posedge clk)
    begin
        flow_resp_t got;
        flow_resp_t exp_r;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_TIMEOUT)
                timeout_sec = cfg_data;
            else
                flow_limit = cfg_data[10:0];
        end
        if (done)
        begin
            got = '{found, created, table_full, flow_protocol, first_seen_ms,
                    last_seen_ms, pkt_total, octet_total, expired_count};
            if (expected_resps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                exp_r = expected_resps.pop_front();
                if (got != exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    int unsigned cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("flow_table_with_aging_core regression: fail");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic flow_key_t rand_key();
        return {$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)};
    endfunction

    task automatic add_req(logic [1:0] req, flow_key_t k, logic [3:0] hint,
                           logic [47:0] t, logic [15:0] len);
        flow_req_t q;
        q = '{req, k, hint, t, len};
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    task automatic add_random_req();
        flow_req_t q;
        int pick;
        q.key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : rand_key();
        q.hint = $urandom_range(0, 1) ? 4'd0 : 4'($urandom);
        q.len = 16'($urandom);
        now_ms = now_ms + $urandom_range(0, 60000);
        if ($urandom_range(0, 29) == 0)
            now_ms = now_ms + $urandom_range(200000, 900000);
        if ($urandom_range(0, 49) == 0)
            now_ms = MAX48 - $urandom_range(0, 2000000);
        q.t_ms = now_ms;
        // occasional timestamp behind the running clock
        if ($urandom_range(0, 19) == 0)
            q.t_ms = (now_ms > 200000) ? now_ms - $urandom_range(0, 200000) : '0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            q.req = REQ_PACKET;
        else if (pick < 80)
            q.req = REQ_LOOKUP;
        else if (pick < 92)
        begin
            q.req = REQ_SWEEP;
            if ($urandom_range(0, 1))
                q.t_ms = q.t_ms + $urandom_range(0, 400000);
        end
        else if (pick < 96)
            q.req = 2'd3;
        else
        begin
            q.req = 2'($urandom);
            q.key = rand_key();
            q.t_ms = rand48();
        end
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || start || expected_resps.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(logic [15:0] tmo, logic [15:0] lim, int n);
        wait_idle();
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MAXFLOW, lim);
        repeat (n) add_random_req();
    endtask

    initial
    begin
        flow_key_t ones;
        flow_key_t zeros;
        rst_n <= 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tbl_valid[i] = 1'b0;
        live_flows = 0;
        timeout_sec = 16'd300;
        flow_limit = 11'd1024;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = rand_key();
        ones = '1;
        zeros = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, class adoption, age boundary, backwards time
        add_req(REQ_PACKET, ones, 4'hF, MAX48, 16'hFFFF);
        add_req(REQ_PACKET, ones, 4'h3, MAX48, 16'hFFFF);
        add_req(REQ_LOOKUP, ones, 4'h0, '0, '0);
        add_req(REQ_PACKET, zeros, 4'h0, '0, '0);
        add_req(REQ_PACKET, zeros, 4'h5, 48'd10, 16'd1);
        add_req(REQ_PACKET, zeros, 4'h9, 48'd20, 16'd2);
        add_req(REQ_LOOKUP, key_pool[0], 4'hA, 48'd5, 16'd7);
        add_req(2'd3, ones, 4'hF, MAX48, 16'hFFFF);
        add_req(REQ_SWEEP, zeros, 4'h0, '0, '0);
        add_req(REQ_SWEEP, zeros, 4'h0, 48'd301019, '0);
        add_req(REQ_LOOKUP, zeros, 4'h0, '0, '0);
        add_req(REQ_SWEEP, ones, 4'hF, 48'd301020, 16'hFFFF);
        add_req(REQ_LOOKUP, zeros, 4'h0, '0, '0);
        add_req(REQ_LOOKUP, ones, 4'h0, '0, '0);
        add_req(REQ_SWEEP, zeros, 4'h0, MAX48, '0);
        add_req(REQ_LOOKUP, ones, 4'h0, '0, '0);

        run_phase(16'd0, 16'd3, 70);
        run_phase(16'hFFFF, 16'd1024, 90);
        run_phase(16'd5, 16'hF801, 60);
        run_phase(16'd30, 16'd16, 80);
        wait_idle();
        quiet_tail = 1'b1;
        run_phase(16'd300, 16'd1024, 100);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_resps.size() == 0)
            $display("flow_table_with_aging_core regression: pass");
        else
            $display("flow_table_with_aging_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
